// ===== sv/lbpe_pkg.sv =====
// Package with shared types and constants for the LED blink pattern encoder.
`timescale 1ns / 1ps
package lbpe_pkg;

  localparam int unsigned NREQ = 3;

  localparam logic [1:0] FUNC_NOTIFY  = 2'd0;
  localparam logic [1:0] FUNC_ATTN    = 2'd1;
  localparam logic [1:0] FUNC_BATTERY = 2'd2;
  localparam logic [1:0] FUNC_SKIP    = 2'd3;

  localparam logic [1:0] MODE_NONE  = 2'd0;
  localparam logic [1:0] MODE_TIMED = 2'd1;
  localparam logic [1:0] MODE_HW    = 2'd2;
  localparam logic [1:0] MODE_RSVD  = 2'd3;

  localparam logic [16:0] TOTAL_MAX = 17'd15000;
  localparam logic [15:0] ON_MAX    = 16'd8000;

  // Quarter-ms slot widths of the 1 s and 8 s windows
  localparam logic [16:0] SLOT_Q_SHORT = 17'd125;
  localparam logic [16:0] SLOT_Q_LONG  = 17'd1000;

  // Twice the window length, numerator base of the cycle count
  localparam logic [14:0] WIN2_SHORT = 15'd2000;
  localparam logic [14:0] WIN2_LONG  = 15'd16000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_DIV,
    ST_SLOT,
    ST_DONE
  } lbpe_state_t;

endpackage

// ===== sv/led_blink_pattern_encoder.sv =====
// Top level of the LED blink pattern encoder: request store, selection and pattern sequencer.
`timescale 1ns / 1ps
// Each accepted transfer with a function below 3 rewrites one of three light requests, and
// each accepted transfer yields one result that describes the request now shown. A timed
// flash runs a 15-step restoring division for the cycle count, then walks the 32 slots of
// the window with one shared subtract and compare unit, first advancing past each flash
// cycle that starts by the slot. The block takes no new transfer while it works; a finished
// result waits in the output register until it is taken.
module led_blink_pattern_encoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_func,
  input  logic [23:0] in_light_color,
  input  logic [1:0]  in_flash_mode,
  input  logic [15:0] in_on_ms,
  input  logic [15:0] in_off_ms,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_source,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic        out_pattern_mode,
  output logic [31:0] out_pattern_bits,
  output logic [3:0]  out_duration_secs,
  output logic [2:0]  out_delay_secs,
  output logic [8:0]  out_dim_time_ms
);
  import lbpe_pkg::*;

  // Request store
  logic [23:0] req_color_r [NREQ];
  logic [1:0]  req_mode_r  [NREQ];
  logic [15:0] req_on_r    [NREQ];
  logic [15:0] req_off_r   [NREQ];

  lbpe_state_t state_r, state_nxt;

  // Working registers
  logic [1:0]  sel_r;
  logic [23:0] color_r;
  logic        pm_r;
  logic        long_r;
  logic [13:0] tot_r;
  logic [13:0] on_r;
  logic [3:0]  dur_r;
  logic [2:0]  delay_r;
  logic [8:0]  dim_r;
  logic [14:0] num_r;
  logic [15:0] rem_r;
  logic [14:0] quo_r;
  logic [3:0]  step_r;
  logic [4:0]  slot_r;
  logic [16:0] u_r;
  logic [11:0] c_r;
  logic [31:0] bits_r;
  logic        out_valid_r;

  logic accept;
  assign accept   = in_valid && in_ready;
  assign in_ready = (state_r == ST_IDLE);

  // Selection and timing setup
  logic [1:0]  sel;
  logic [15:0] s_on, s_off, onc, offc, lim;
  logic [16:0] sum;
  logic [13:0] tot;
  logic [15:0] shorter;
  logic        pm, lng;
  logic [2:0]  dly;
  logic [8:0]  dim;
  logic [15:0] on3;

  always_comb begin
    if (req_color_r[0] != 24'd0) sel = FUNC_NOTIFY;
    else if (req_color_r[1] != 24'd0) sel = FUNC_ATTN;
    else sel = FUNC_BATTERY;
    s_on  = req_on_r[sel];
    s_off = req_off_r[sel];
    pm    = (req_mode_r[sel] == MODE_TIMED) && (s_on != 16'd0) && (s_off != 16'd0);
    sum   = {1'b0, s_on} + {1'b0, s_off};
    onc   = s_on;
    offc  = s_off;
    if (sum > TOTAL_MAX) begin
      if (s_on > ON_MAX) onc = ON_MAX;
      lim = TOTAL_MAX[15:0] - onc;
      if (s_off > lim) offc = lim;
    end else begin
      lim = 16'd0;
    end
    tot     = 14'(onc + offc);
    shorter = (offc > onc) ? onc : offc;
    if (shorter > 16'd500) dim = 9'd500;
    else if (shorter > 16'd190) dim = 9'd190;
    else if (shorter > 16'd95) dim = 9'd95;
    else dim = 9'd50;
    lng = !((tot < 14'd8000) && (onc < 16'd1000));
    on3 = 16'(onc * 3);
    if (lng) dly = 3'd0;
    else if (tot < 14'd2000) dly = (offc > on3) ? 3'd1 : 3'd0;
    else dly = 3'(32'(tot >= 14'd2000) + 32'(tot >= 14'd3000) + 32'(tot >= 14'd4000)
                + 32'(tot >= 14'd5000) + 32'(tot >= 14'd6000) + 32'(tot >= 14'd7000));
  end

  // Shared subtract and compare unit
  logic [15:0] div_part, div_den;
  logic        div_ge;
  logic [16:0] tot4, hi4;
  logic [11:0] cyc;
  logic        c_ok, adj;

  always_comb begin
    div_part = {rem_r[14:0], num_r[14]};
    div_den  = {tot_r, 2'b0} >> 1;
    div_ge   = (div_part >= div_den);
    tot4     = {1'b0, tot_r, 2'b0};
    hi4      = {1'b0, on_r, 2'b0} + 17'd3;
    cyc      = (quo_r == 15'd0) ? 12'd1 : quo_r[11:0];
    c_ok     = (c_r < cyc);
    adj      = c_ok && (u_r >= tot4);
  end

  // Request store write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NREQ; i++) begin
        req_color_r[i] <= '0;
        req_mode_r[i]  <= '0;
        req_on_r[i]    <= '0;
        req_off_r[i]   <= '0;
      end
    end else if (accept && (in_func < 2'(NREQ))) begin
      req_color_r[in_func] <= in_light_color;
      req_mode_r[in_func]  <= in_flash_mode;
      req_on_r[in_func]    <= in_on_ms;
      req_off_r[in_func]   <= in_off_ms;
    end
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (accept) state_nxt = ST_SETUP;
      ST_SETUP: state_nxt = pm ? ST_DIV : ST_DONE;
      ST_DIV:   if (step_r == 4'd0) state_nxt = ST_SLOT;
      ST_SLOT:  if (!adj && (slot_r == 5'd31)) state_nxt = ST_DONE;
      ST_DONE:  if (!out_valid_r || out_ready) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Datapath sequencing
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_SETUP: begin
        sel_r   <= sel;
        color_r <= req_color_r[sel];
        pm_r    <= pm;
        long_r  <= lng;
        tot_r   <= tot;
        on_r    <= onc[13:0];
        dur_r   <= (pm && lng) ? 4'd8 : 4'd1;
        delay_r <= pm ? dly : 3'd0;
        dim_r   <= pm ? dim : 9'd50;
        num_r   <= (lng ? WIN2_LONG : WIN2_SHORT) + {1'b0, tot};
        rem_r   <= '0;
        quo_r   <= '0;
        step_r  <= 4'd14;
        slot_r  <= '0;
        u_r     <= 17'd3;
        c_r     <= '0;
        bits_r  <= '0;
      end
      ST_DIV: begin
        // One restoring division step per cycle
        num_r  <= {num_r[13:0], 1'b0};
        rem_r  <= div_ge ? (div_part - div_den) : div_part;
        quo_r  <= {quo_r[13:0], div_ge};
        step_r <= step_r - 4'd1;
      end
      ST_SLOT: begin
        if (adj) begin
          // Advance to the latest flash cycle that starts by this slot
          u_r <= u_r - tot4;
          c_r <= c_r + 12'd1;
        end else begin
          bits_r[slot_r] <= c_ok && (u_r < hi4);
          slot_r <= slot_r + 5'd1;
          u_r    <= u_r + (long_r ? SLOT_Q_LONG : SLOT_Q_SHORT);
        end
      end
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == ST_DONE) && (!out_valid_r || out_ready)) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == ST_DONE) && (!out_valid_r || out_ready)) begin
      out_source        <= sel_r;
      out_red           <= color_r[23:16];
      out_green         <= color_r[15:8];
      out_blue          <= color_r[7:0];
      out_pattern_mode  <= pm_r;
      out_pattern_bits  <= pm_r ? bits_r : 32'd0;
      out_duration_secs <= dur_r;
      out_delay_secs    <= delay_r;
      out_dim_time_ms   <= dim_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ===== sv/lbpe_checker.sv =====
// Port-level checker for the LED blink pattern encoder, bound to the top level.
`timescale 1ns / 1ps
module lbpe_assertions (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_pattern_mode,
  input logic [31:0] out_pattern_bits,
  input logic [3:0]  out_duration_secs,
  input logic [2:0]  out_delay_secs,
  input logic [8:0]  out_dim_time_ms
);

  // Hold a pending result until transfer
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("result dropped before transfer");

  // Drop ready while an accepted item is at work
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready) else $error("input taken while busy");

  // Direct results carry neutral pattern settings
  a_direct: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_pattern_mode |-> out_pattern_bits == 32'd0
      && out_duration_secs == 4'd1 && out_delay_secs == 3'd0 && out_dim_time_ms == 9'd50)
    else $error("direct result with pattern settings");

  // Long window has no extra delay
  a_long: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_duration_secs == 4'd8 |-> out_delay_secs == 3'd0)
    else $error("delay set in long window");

endmodule

bind led_blink_pattern_encoder lbpe_assertions u_lbpe_assertions (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_pattern_mode(out_pattern_mode),
  .out_pattern_bits(out_pattern_bits), .out_duration_secs(out_duration_secs),
  .out_delay_secs(out_delay_secs), .out_dim_time_ms(out_dim_time_ms)
);
